@@ design/ssc_pkg.sv @@
// Shared types and constants for the surface curvature stencil.
package ssc_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // register indexes on the csr port
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [12:0] WIDTH_RESET  = 13'd256;
   localparam logic [15:0] HEIGHT_RESET = 16'd256;

   // one stencil result waiting for the curvature divide
   typedef struct packed {
      logic [11:0]        cx;
      logic [15:0]        cy;
      logic signed [16:0] p;
      logic signed [16:0] q;
      logic signed [17:0] r;
      logic signed [17:0] t;
      logic signed [17:0] s;
      logic signed [18:0] m;
      logic               last;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_FIN  = 4'b1000
   } back_state_type;

endpackage

@@ design/ssc_front.sv @@
// Front end: raster counters, line stores, 3x3 window and the difference terms.
module ssc_front import ssc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_height_sample,
   input  logic [12:0]        image_width,
   input  logic [15:0]        image_height,
   input  logic               fifo_full,
   output logic               push,
   output item_type           push_item
);

   logic [COL_W-1:0]   col_ff, col_in;
   logic [15:0]        row_ff, row_in;
   logic               b_ff;
   logic [COL_W-1:0]   b_addr_ff;
   logic signed [15:0] b_sample_ff;
   logic [11:0]        b_cx_ff;
   logic [15:0]        b_cy_ff;
   logic               b_last_ff;
   logic               b_int_ff;
   logic signed [15:0] upper_rd_ff, mid_rd_ff;
   logic signed [15:0] win_ff [0:2][0:2];
   logic signed [15:0] win_in [0:2][0:2];
   logic [15:0]        upper_mem [0:MAX_WIDTH-1];
   logic [15:0]        mid_mem   [0:MAX_WIDTH-1];

   logic        accept;
   logic [12:0] w_eff;
   logic [12:0] col_next;
   logic [16:0] row_next;
   logic        row_end, frame_end, interior;

   assign req_ready = !b_ff && !fifo_full;
   assign accept    = req_valid && req_ready;

   // raster position of the word being taken
   always_comb begin
      w_eff     = (image_width > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : image_width;
      col_next  = {1'b0, col_ff} + 13'd1;
      row_next  = {1'b0, row_ff} + 17'd1;
      row_end   = col_next >= w_eff;
      frame_end = row_next >= {1'b0, image_height};
      interior  = (col_ff >= COL_W'(2)) && (row_ff >= 16'd2) && ({1'b0, col_ff} < w_eff);
      col_in    = col_ff;
      row_in    = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? 16'd0 : row_next[15:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         b_ff   <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         b_ff   <= accept;
      end
   end

   // word held for the store update cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         b_addr_ff   <= col_ff;
         b_sample_ff <= req_height_sample;
         b_cx_ff     <= 12'(col_ff - COL_W'(1));
         b_cy_ff     <= row_ff - 16'd1;
         b_last_ff   <= row_end && frame_end;
         b_int_ff    <= interior;
      end
   end

   // line stores: read on accept, shift down one row the cycle after
   always_ff @(posedge clock) begin
      if (accept) begin
         upper_rd_ff <= upper_mem[col_ff];
         mid_rd_ff   <= mid_mem[col_ff];
      end
      if (b_ff) begin
         upper_mem[b_addr_ff] <= mid_rd_ff;
         mid_mem[b_addr_ff]   <= b_sample_ff;
      end
   end

   // window shifts left, new column enters on the right
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k][0] = win_ff[k][1];
         win_in[k][1] = win_ff[k][2];
      end
      win_in[0][2] = upper_rd_ff;
      win_in[1][2] = mid_rd_ff;
      win_in[2][2] = b_sample_ff;
   end

   always_ff @(posedge clock) begin
      if (b_ff) begin
         win_ff <= win_in;
      end
   end

   // central differences on the new window
   logic signed [17:0] z10, z11, z12, z01, z21, z00, z20, z02, z22;
   logic signed [17:0] r_val, t_val;

   always_comb begin
      z10 = 18'(win_in[1][0]);
      z11 = 18'(win_in[1][1]);
      z12 = 18'(win_in[1][2]);
      z01 = 18'(win_in[0][1]);
      z21 = 18'(win_in[2][1]);
      z00 = 18'(win_in[0][0]);
      z20 = 18'(win_in[2][0]);
      z02 = 18'(win_in[0][2]);
      z22 = 18'(win_in[2][2]);
      r_val = z12 - (z11 <<< 1) + z10;
      t_val = z21 - (z11 <<< 1) + z01;
      push_item.cx   = b_cx_ff;
      push_item.cy   = b_cy_ff;
      push_item.p    = 17'(z12 - z10);
      push_item.q    = 17'(z21 - z01);
      push_item.r    = r_val;
      push_item.t    = t_val;
      push_item.s    = z00 - z20 - z02 + z22;
      push_item.m    = 19'(r_val) + 19'(t_val);
      push_item.last = b_last_ff;
   end

   assign push = b_ff && b_int_ff;

endmodule

@@ design/ssc_fifo.sv @@
// Short queue of stencil results between the front and back ends.
module ssc_fifo import ssc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type pop_item,
   output logic     full,
   output logic     empty
);

   item_type           entry_ff [0:FIFO_DEPTH-1];
   logic [FIFO_AW-1:0] wr_ff, rd_ff;
   logic [FIFO_AW:0]   count_ff, count_in;

   assign full     = count_ff == (FIFO_AW+1)'(FIFO_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_item = entry_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_item;
      end
   end

endmodule

@@ design/ssc_back.sv @@
// Back end: Gaussian curvature by shared multiplier and bit-serial divide.
module ssc_back import ssc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               fifo_empty,
   input  item_type           pop_item,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [11:0]        rsp_center_x,
   output logic [15:0]        rsp_center_y,
   output logic signed [16:0] rsp_grad_x_twice,
   output logic signed [16:0] rsp_grad_y_twice,
   output logic signed [17:0] rsp_second_xx,
   output logic signed [17:0] rsp_second_yy,
   output logic signed [17:0] rsp_cross_times_four,
   output logic signed [18:0] rsp_mean_curv_twice,
   output logic signed [31:0] rsp_gauss_curv,
   output logic               rsp_frame_last
);

   back_state_type     state_ff;
   item_type           item_ff;
   logic [2:0]         step_ff;
   logic [5:0]         cnt_ff;
   logic signed [35:0] prod_ff;
   // D can reach just over 2^33, so D^2 needs 67 bits
   logic [33:0]        d_ff;
   logic signed [39:0] num_ff;
   logic [66:0]        den_ff;
   logic [66:0]        rem_ff;
   logic [40:0]        nbits_ff;
   logic [40:0]        quo_ff;
   logic               out_valid_ff;

   logic signed [17:0] mul_a, mul_b;
   logic [38:0]        mag;
   logic [67:0]        trial;
   logic               ge;
   logic               round_up;
   logic [41:0]        q_rnd;
   logic signed [31:0] gauss;
   logic               load_out;

   assign pop      = (state_ff == ST_IDLE) && !fifo_empty;
   assign load_out = (state_ff == ST_FIN) && (!out_valid_ff || rsp_ready);

   // multiplier operands per step
   always_comb begin
      mul_a = item_ff.r;
      mul_b = item_ff.t;
      case (step_ff)
         3'd0: begin mul_a = 18'(item_ff.p); mul_b = 18'(item_ff.p); end
         3'd1: begin mul_a = 18'(item_ff.q); mul_b = 18'(item_ff.q); end
         3'd2: begin mul_a = item_ff.r;      mul_b = item_ff.t;      end
         3'd3: begin mul_a = item_ff.s;      mul_b = item_ff.s;      end
         3'd4: begin
            mul_a = $signed({1'b0, d_ff[16:0]});
            mul_b = $signed({1'b0, d_ff[16:0]});
         end
         3'd5: begin
            mul_a = $signed({1'b0, d_ff[33:17]});
            mul_b = $signed({1'b0, d_ff[16:0]});
         end
         3'd6: begin
            mul_a = $signed({1'b0, d_ff[33:17]});
            mul_b = $signed({1'b0, d_ff[33:17]});
         end
         default: begin mul_a = item_ff.r; mul_b = item_ff.t; end
      endcase
   end

   // divide step, rounding and saturation
   always_comb begin
      mag      = num_ff[39] ? 39'(-num_ff) : num_ff[38:0];
      trial    = {rem_ff, nbits_ff[40]};
      ge       = trial >= {1'b0, den_ff};
      round_up = {rem_ff, 1'b0} >= {1'b0, den_ff};
      q_rnd    = {1'b0, quo_ff} + 42'(round_up);
      if (num_ff[39]) begin
         gauss = (q_rnd > 42'h0_8000_0000) ? 32'sh8000_0000 : 32'(-q_rnd);
      end else begin
         gauss = (q_rnd > 42'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q_rnd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: if (!fifo_empty) state_ff <= ST_MUL;
            ST_MUL:  if (step_ff == 3'd7) state_ff <= ST_DIV;
            ST_DIV:  if (cnt_ff == '0) state_ff <= ST_FIN;
            ST_FIN:  if (load_out) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath sequencing
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         ST_IDLE: begin
            item_ff <= pop_item;
            step_ff <= 3'd0;
         end
         ST_MUL: begin
            step_ff <= step_ff + 3'd1;
            case (step_ff)
               3'd1: d_ff   <= 34'h4_0000 + 34'(prod_ff[32:0]);
               3'd2: d_ff   <= d_ff + 34'(prod_ff[32:0]);
               3'd3: num_ff <= 40'(prod_ff) <<< 4;
               3'd4: num_ff <= num_ff - 40'(prod_ff);
               3'd5: den_ff <= 67'(prod_ff[34:0]);
               3'd6: den_ff <= den_ff + (67'(prod_ff[33:0]) << 18);
               3'd7: begin
                  den_ff   <= den_ff + (67'(prod_ff[33:0]) << 34);
                  rem_ff   <= 67'(mag[38:9]);
                  nbits_ff <= {mag[8:0], 32'd0};
                  quo_ff   <= '0;
                  cnt_ff   <= 6'd40;
               end
               default: d_ff <= d_ff;
            endcase
         end
         ST_DIV: begin
            rem_ff   <= ge ? 67'(trial - {1'b0, den_ff}) : trial[66:0];
            quo_ff   <= {quo_ff[39:0], ge};
            nbits_ff <= {nbits_ff[39:0], 1'b0};
            cnt_ff   <= cnt_ff - 6'd1;
         end
         default: cnt_ff <= cnt_ff;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_center_x         <= item_ff.cx;
         rsp_center_y         <= item_ff.cy;
         rsp_grad_x_twice     <= item_ff.p;
         rsp_grad_y_twice     <= item_ff.q;
         rsp_second_xx        <= item_ff.r;
         rsp_second_yy        <= item_ff.t;
         rsp_cross_times_four <= item_ff.s;
         rsp_mean_curv_twice  <= item_ff.m;
         rsp_gauss_curv       <= gauss;
         rsp_frame_last       <= item_ff.last;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

@@ design/stencil_surface_curvature.sv @@
// Top level of the surface curvature stencil.
//
//   channel | direction | handshake              | word
//   req     | in        | req_valid / req_ready  | one Q8.8 height sample
//   rsp     | out       | rsp_valid / rsp_ready  | curvature terms of one interior pixel
//   csr     | in        | csr_we                 | image_width or image_height
//
// Each height word gets a line-store read, then write-back; none is taken in between.
// Each interior result passes through the back end in 8 steps on the shared
// 18x18 multiplier, 41 divide steps of one quotient bit each, then rounding.
// A 4-entry queue parts the two ends; the front also stalls while the queue is full.
// Reset clears counters, queue and handshakes; line stores hold garbage until written.
module stencil_surface_curvature import ssc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_height_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [11:0]        rsp_center_x,
   output logic [15:0]        rsp_center_y,
   output logic signed [16:0] rsp_grad_x_twice,
   output logic signed [16:0] rsp_grad_y_twice,
   output logic signed [17:0] rsp_second_xx,
   output logic signed [17:0] rsp_second_yy,
   output logic signed [17:0] rsp_cross_times_four,
   output logic signed [18:0] rsp_mean_curv_twice,
   output logic signed [31:0] rsp_gauss_curv,
   output logic               rsp_frame_last,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);

   logic [12:0] image_width_ff;
   logic [15:0] image_height_ff;
   logic        push, pop, fifo_full, fifo_empty;
   item_type    push_item, pop_item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[12:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            default:          image_width_ff  <= image_width_ff;
         endcase
      end
   end

   ssc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_height_sample (req_height_sample),
      .image_width       (image_width_ff),
      .image_height      (image_height_ff),
      .fifo_full         (fifo_full),
      .push              (push),
      .push_item         (push_item)
   );

   ssc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   ssc_back u_back (
      .clock                (clock),
      .reset                (reset),
      .fifo_empty           (fifo_empty),
      .pop_item             (pop_item),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_center_x         (rsp_center_x),
      .rsp_center_y         (rsp_center_y),
      .rsp_grad_x_twice     (rsp_grad_x_twice),
      .rsp_grad_y_twice     (rsp_grad_y_twice),
      .rsp_second_xx        (rsp_second_xx),
      .rsp_second_yy        (rsp_second_yy),
      .rsp_cross_times_four (rsp_cross_times_four),
      .rsp_mean_curv_twice  (rsp_mean_curv_twice),
      .rsp_gauss_curv       (rsp_gauss_curv),
      .rsp_frame_last       (rsp_frame_last)
   );

endmodule
